// ----- rtl/gda_pkg.sv -----
// Package for the Gregorian date adder: calendar constants, the month length
// function and the status struct of the year residue unit.
// No dependencies.
package gda_pkg;

  localparam int unsigned YEAR_BITS_DEF  = 16;
  localparam int unsigned COUNT_BITS_DEF = 16;

  localparam logic [8:0] CENTURY_YEARS = 9'd100;
  localparam logic [8:0] CENTURY_2     = 9'd200;
  localparam logic [8:0] CENTURY_3     = 9'd300;
  localparam logic [8:0] CYCLE_LAST    = 9'd399;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  localparam logic [4:0] DAYS_31 = 5'd31;
  localparam logic [4:0] DAYS_30 = 5'd30;
  localparam logic [4:0] DAYS_29 = 5'd29;
  localparam logic [4:0] DAYS_28 = 5'd28;
  localparam logic [4:0] DAY_FIRST = 5'd1;

  // status of the residue unit
  typedef struct packed {
    logic       busy;
    logic       done;
    logic [8:0] rem;
  } mod_status_t;

  // rem is year mod 400, low2 the two low year bits
  function automatic logic leap_year(input logic [8:0] rem, input logic [1:0] low2);
    logic century;
    century = (rem == CENTURY_YEARS) || (rem == CENTURY_2) || (rem == CENTURY_3);
    return (rem == 9'd0) || ((low2 == 2'd0) && !century);
  endfunction

  // zero for a month code outside 1..12
  function automatic logic [4:0] month_length(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAYS_31;
      4'd4, 4'd6, 4'd9, 4'd11:                   len = DAYS_30;
      MONTH_FEB:                                 len = leap ? DAYS_29 : DAYS_28;
      default:                                   len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

// ----- rtl/gregorian_date_add_days.sv -----
// Gregorian date adder top level: sequencer and month step datapath.
// Depends on gda_pkg and gda_mod400.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------------------------
//   in      | input     | in_valid_i/in_ready_o | start_day, start_month, start_year,
//           |           |                       | days_to_add
//   out     | output    | out_valid_o/out_ready_i | result_day, result_month, result_year,
//           |           |                       | date_valid, year_overflow
//
// A transaction first reduces the year mod 400 and checks the date, then walks
// the count forward one month per step, ends the walk and loads the result
// register. The month step loop runs through the shared add/compare. Reset clears
// the sequencer and the output slot. The result waits in an output register, so
// the next transaction is accepted while it stalls there; that one holds its
// result until the slot frees.
module gregorian_date_add_days #(
  parameter int unsigned YEAR_BITS  = gda_pkg::YEAR_BITS_DEF,
  parameter int unsigned COUNT_BITS = gda_pkg::COUNT_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [4:0]  start_day_i,
  input  logic [3:0]  start_month_i,
  input  logic [15:0] start_year_i,
  input  logic [15:0] days_to_add_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  result_day_o,
  output logic [3:0]  result_month_o,
  output logic [15:0] result_year_o,
  output logic        date_valid_o,
  output logic        year_overflow_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_CHECK,
    ST_STEP,
    ST_FINISH
  } state_e;

  state_e               state_q;
  logic [4:0]           day_q;
  logic [3:0]           month_q;
  logic [YEAR_BITS-1:0] year_q;
  logic [COUNT_BITS-1:0] cnt_q;
  logic [8:0]           rem_q;
  logic                 valid_q, ovf_q;

  logic                 out_valid_q;
  logic [4:0]           res_day_q;
  logic [3:0]           res_month_q;
  logic [15:0]          res_year_q;
  logic                 res_valid_q, res_ovf_q;

  logic                 in_fire;
  logic                 slot_free;
  logic [YEAR_BITS-1:0] year_in;
  gda_pkg::mod_status_t mod_st;

  logic                  leap;
  logic [4:0]            dim;
  logic [COUNT_BITS:0]   sum;
  logic [5:0]            consume;
  logic [8:0]            rem_inc;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign year_in    = YEAR_BITS'(start_year_i);

  gda_mod400 #(
    .YEAR_BITS(YEAR_BITS)
  ) u_mod400 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_fire),
    .value_i (year_in),
    .status_o(mod_st)
  );

  // leap rule from the tracked residue and the year's low bits
  assign leap    = gda_pkg::leap_year(rem_q, year_q[1:0]);
  assign dim     = gda_pkg::month_length(month_q, leap);
  assign sum     = {1'b0, cnt_q} + (COUNT_BITS + 1)'(day_q);
  assign consume = 6'(dim - day_q) + 6'd1;
  assign rem_inc = (rem_q == gda_pkg::CYCLE_LAST) ? 9'd0 : 9'(rem_q + 9'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      day_q       <= '0;
      month_q     <= '0;
      year_q      <= '0;
      cnt_q       <= '0;
      rem_q       <= '0;
      valid_q     <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      res_day_q   <= '0;
      res_month_q <= '0;
      res_year_q  <= '0;
      res_valid_q <= 1'b0;
      res_ovf_q   <= 1'b0;
    end else begin
      if (state_q == ST_FINISH && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            day_q   <= start_day_i;
            month_q <= start_month_i;
            year_q  <= year_in;
            cnt_q   <= COUNT_BITS'(days_to_add_i);
            valid_q <= 1'b0;
            ovf_q   <= 1'b0;
            state_q <= ST_REDUCE;
          end
        end
        ST_REDUCE: begin
          if (mod_st.done) begin
            rem_q   <= mod_st.rem;
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (dim != 5'd0 && day_q >= gda_pkg::DAY_FIRST && day_q <= dim) begin
            valid_q <= 1'b1;
            state_q <= ST_STEP;
          end else begin
            state_q <= ST_FINISH;
          end
        end
        ST_STEP: begin
          if (cnt_q == '0) begin
            state_q <= ST_FINISH;
          end else if (sum <= (COUNT_BITS + 1)'(dim)) begin
            day_q   <= sum[4:0];
            cnt_q   <= '0;
            state_q <= ST_FINISH;
          end else begin
            cnt_q <= cnt_q - COUNT_BITS'(consume);
            day_q <= gda_pkg::DAY_FIRST;
            if (month_q >= gda_pkg::MONTH_DEC) begin
              if (year_q == '1) begin
                // past the last representable December: clamp
                ovf_q   <= 1'b1;
                day_q   <= gda_pkg::DAYS_31;
                month_q <= gda_pkg::MONTH_DEC;
                state_q <= ST_FINISH;
              end else begin
                month_q <= gda_pkg::MONTH_JAN;
                year_q  <= year_q + 1'b1;
                rem_q   <= rem_inc;
              end
            end else begin
              month_q <= month_q + 4'd1;
            end
          end
        end
        ST_FINISH: begin
          if (slot_free) begin
            res_day_q   <= day_q;
            res_month_q <= month_q;
            res_year_q  <= 16'(year_q);
            res_valid_q <= valid_q;
            res_ovf_q   <= ovf_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_day_o    = res_day_q;
  assign result_month_o  = res_month_q;
  assign result_year_o   = res_year_q;
  assign date_valid_o    = res_valid_q;
  assign year_overflow_o = res_ovf_q;

endmodule

// ----- rtl/gda_mod400.sv -----
// Residue unit: year mod 400 by reciprocal multiplication, a registered product step then a registered residue step.
// Depends on gda_pkg.
module gda_mod400 #(
  parameter int unsigned YEAR_BITS = gda_pkg::YEAR_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [YEAR_BITS-1:0]  value_i,
  output gda_pkg::mod_status_t  status_o
);

  // year mod 400 = 16 * ((year >> 4) mod 25) + year[3:0]; the quotient by 25
  // comes from a rounded-up reciprocal, exact over the whole year range
  localparam int unsigned   PW      = 2 * YEAR_BITS;
  localparam int unsigned   SHIFT   = YEAR_BITS + 1;
  localparam logic [63:0]   RECIP64 = ((64'd1 << SHIFT) + 64'd24) / 64'd25;
  localparam logic [PW-1:0] RECIP   = PW'(RECIP64);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic                 phase_q, phase_d;
  logic [YEAR_BITS-1:0] val_q, val_d;
  logic [PW-1:0]        prod_q, prod_d;
  logic [8:0]           rem_q, rem_d;
  logic [4:0]           quot5;
  logic [4:0]           quot25;
  logic [4:0]           res25;

  // only the quotient mod 32 matters, the residue by 25 fits in five bits
  assign quot5  = prod_q[SHIFT +: 5];
  assign quot25 = 5'({quot5, 4'b0} + {1'b0, quot5, 3'b0} + {4'b0, quot5});
  assign res25  = val_q[8:4] - quot25;

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    phase_d = phase_q;
    val_d   = val_q;
    prod_d  = prod_q;
    rem_d   = rem_q;
    if (start_i) begin
      busy_d  = 1'b1;
      phase_d = 1'b0;
      val_d   = value_i;
    end else if (busy_q) begin
      if (!phase_q) begin
        prod_d  = PW'(val_q[YEAR_BITS-1:4]) * RECIP;
        phase_d = 1'b1;
      end else begin
        rem_d  = {res25, val_q[3:0]};
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      phase_q <= 1'b0;
      val_q   <= '0;
      prod_q  <= '0;
      rem_q   <= '0;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      phase_q <= phase_d;
      val_q   <= val_d;
      prod_q  <= prod_d;
      rem_q   <= rem_d;
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign status_o.rem  = rem_q;

endmodule

// ----- rtl/gda_checker.sv -----
// Port-level checks for the Gregorian date adder, bound to the top level.
// Depends on gregorian_date_add_days ports only.
module gda_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [4:0]  start_day_i,
  input logic [3:0]  start_month_i,
  input logic [15:0] start_year_i,
  input logic [15:0] days_to_add_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [4:0]  result_day_o,
  input logic [3:0]  result_month_o,
  input logic [15:0] result_year_o,
  input logic        date_valid_o,
  input logic        year_overflow_o
);

  // result held until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_year_o)
      && $stable(result_day_o) && $stable(result_month_o))
    else $error("result changed while stalled");

  // offered transaction held until taken
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(start_day_i)
      && $stable(start_month_i) && $stable(start_year_i) && $stable(days_to_add_i))
    else $error("input transaction changed while waiting");

  // one transaction at a time in the datapath
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready high right after an accepted transaction");

  a_valid_date: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && date_valid_o |-> result_day_o >= 5'd1 && result_month_o >= 4'd1
      && result_month_o <= 4'd12)
    else $error("valid result outside the calendar");

  a_ovf_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && year_overflow_o |-> date_valid_o && result_day_o == 5'd31
      && result_month_o == 4'd12)
    else $error("overflow without 31 December clamp");

endmodule

bind gregorian_date_add_days gda_checker u_gda_checker (.*);
